[rtl/core/s256_pkg.sv]
`default_nettype none

package s256_pkg;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned BLOCK_AW    = 4;
	localparam int unsigned ROUNDS      = 64;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] FILL_TOP = 6'd63;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

[rtl/core/s256_ram.sv]
`default_nettype none

module s256_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/sha256_byte_stream_hash_unit.sv]
`default_nettype none

// SHA-256 over a byte stream. Each accepted word on the byte channel carries at
// most one message byte (has_byte) and may close the message (end_of_message);
// an idle word with neither flag changes nothing. After a plain byte the block is
// ready again on the next cycle. Bytes are packed into 32-bit words in a 16-entry
// block RAM; the 64th byte of a block starts a compression that stalls the byte
// channel: it streams the block out of the RAM (one read per cycle, registered
// read data) into the schedule window, runs 64 rounds at one round per cycle,
// and then folds the result into the chaining words. Closing a message feeds the
// padding marker, zero bytes and the 64-bit big-endian bit length through the
// same byte path at one byte per cycle while no compression runs, so finishing
// costs up to 72 padding bytes plus one or two compressions; then eight digest
// words, H0 first, leave through a registered output that honors digest_stall.
// After the eighth word the unit returns to the initial hash values and takes
// the next message while that word may still wait.

module sha256_byte_stream_hash_unit
	import s256_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        end_of_message,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic      [31:0] digest_word,
	output logic      [2:0]  word_index,
	output logic             last_word
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t      st_q;
	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [BLOCK_WORDS];
	logic [63:0] bitlen_q;
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic [23:0] part_q;
	logic        fin_q;
	logic        mark_q;
	logic        len_act_q;
	logic        last_q;
	logic [4:0]  ld_cnt_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;

	logic        accept;
	logic        put_en;
	logic [7:0]  put_byte;
	logic        put_len;
	logic        blk_full;
	logic [63:0] len_nx;
	logic        ram_we;
	logic [31:0] ram_rd;
	logic        ram_re;
	logic        out_free;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;

	assign accept   = byte_valid && !byte_stall;
	assign out_free = !digest_valid || !digest_stall;
	assign len_nx   = bitlen_q + (has_byte ? 64'd8 : 64'd0);

	// Pick the byte that enters the block: a message byte while idle, else padding.
	always_comb begin
		put_en   = 1'b0;
		put_byte = data_byte;
		put_len  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				put_en = accept && has_byte;
			end
			ST_PAD: begin
				put_en = 1'b1;
				priority if (mark_q) begin
					put_byte = PAD_MARK;
				end else if (len_act_q || fill_q == LEN_POS) begin
					put_byte = len_q[63:56];
					put_len  = 1'b1;
				end else begin
					put_byte = 8'h00;
				end
			end
			ST_LOAD, ST_ROUND, ST_ADD, ST_OUT: begin
				put_en = 1'b0;
			end
			default: begin
				put_en = 1'b0;
			end
		endcase
	end

	assign blk_full = put_en && fill_q == FILL_TOP;
	assign ram_we   = put_en && fill_q[1:0] == 2'd3;
	assign ram_re   = st_q == ST_LOAD;

	s256_ram #(
		.WIDTH(32),
		.DEPTH(BLOCK_WORDS)
	) u_blk_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(fill_q[5:2]),
		.wr_data({part_q, put_byte}),
		.rd_en  (ram_re),
		.rd_addr(ld_cnt_q[BLOCK_AW-1:0]),
		.rd_data(ram_rd)
	);

	// One compression round and the next schedule word.
	always_comb begin
		t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[rnd_q] + w_q[0];
		t2 = big_sig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
	end

	assign byte_stall = st_q != ST_IDLE;

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			fill_q       <= '0;
			bitlen_q     <= '0;
			fin_q        <= 1'b0;
			mark_q       <= 1'b0;
			len_act_q    <= 1'b0;
			last_q       <= 1'b0;
			ld_cnt_q     <= '0;
			rnd_q        <= '0;
			oidx_q       <= '0;
			digest_valid <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else begin
			if (put_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (st_q == ST_OUT && out_free) begin
				digest_valid <= 1'b1;
			end else if (digest_valid && !digest_stall) begin
				digest_valid <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						bitlen_q <= len_nx;
						if (end_of_message) begin
							fin_q     <= 1'b1;
							mark_q    <= 1'b1;
							len_act_q <= 1'b0;
						end
						priority if (blk_full) begin
							ld_cnt_q <= '0;
							st_q     <= ST_LOAD;
						end else if (end_of_message) begin
							st_q <= ST_PAD;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b0;
					if (put_len) begin
						len_act_q <= 1'b1;
					end
					if (blk_full) begin
						last_q   <= put_len;
						ld_cnt_q <= '0;
						st_q     <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ld_cnt_q <= ld_cnt_q + 5'd1;
					if (ld_cnt_q == 5'(BLOCK_WORDS)) begin
						rnd_q <= '0;
						st_q  <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					oidx_q <= '0;
					priority if (last_q) begin
						st_q <= ST_OUT;
					end else if (fin_q) begin
						st_q <= ST_PAD;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							// Restart the chain for the next message.
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= INIT_H[i];
							end
							bitlen_q  <= '0;
							fin_q     <= 1'b0;
							last_q    <= 1'b0;
							len_act_q <= 1'b0;
							st_q      <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		if (put_en && fill_q[1:0] != 2'd3) begin
			part_q <= {part_q[15:0], put_byte};
		end
		if (st_q == ST_IDLE && accept && end_of_message) begin
			len_q <= len_nx;
		end else if (st_q == ST_PAD && put_len) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (st_q == ST_LOAD) begin
			if (ld_cnt_q == '0) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= chain_q[i];
				end
			end else begin
				for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[BLOCK_WORDS-1] <= ram_rd;
			end
		end
		if (st_q == ST_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_WORDS-1] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (st_q == ST_OUT && out_free) begin
			digest_word <= chain_q[oidx_q];
			word_index  <= oidx_q;
			last_word   <= oidx_q == 3'd7;
		end
	end

	// Consecutive digest words count up, wrapping from the last word to the next digest.
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall |=>
			!digest_valid || word_index == $past(word_index) + 3'd1)
		else $error("digest word index out of order");

	// A compression always starts on a block boundary.
	a_load_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LOAD |-> fill_q == '0)
		else $error("compression started on a partial block");

	// The last round hands over to the chain update.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_ROUND && rnd_q == 6'(ROUNDS - 1) |=> st_q == ST_ADD)
		else $error("round loop did not end after the last round");

	// Digest words leave only after the final padded block.
	a_out_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OUT |-> fill_q == '0 && last_q && fin_q)
		else $error("digest output before padding finished");

endmodule

`default_nettype wire

[test/sha256_byte_stream_hash_unit_test.sv]
`default_nettype none

module sha256_byte_stream_hash_unit_test;

	// Watchdog: cycles with no word accepted on either channel before giving up.
	// The longest quiet stretch is the deliberate digest hold-off (HOLD_CYCLES) plus
	// one closing message (up to 72 padding bytes and two compressions).
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AT_WORD = 16;
	localparam int TAIL_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 120;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_CHAIN [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// One word for the byte channel, with the sender's idle time after it and
	// whether the sender must wait for all outstanding digests before offering it.
	typedef struct {
		logic [7:0] data;
		logic       has;
		logic       eom;
		int         gap;
		bit         drain;
	} feed_item_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_part_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        digest_valid;
	logic        digest_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_byte_stream_hash_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_stall   (digest_stall),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	// Predicted hash state, advanced on every accepted byte-channel word.
	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	logic [5:0]  fill;
	logic [63:0] msg_bits;

	feed_item_t   byte_feed [$];
	digest_part_t digest_due [$];

	int  mismatches = 0;
	int  feed_count = 0;
	bit  calm_feed = 1'b0;
	bit  drain_next = 1'b0;

	// driver and monitor working state
	bit         feed_offer;
	int         feed_idle = 0;
	int         cur_gap = 0;
	feed_item_t feed_now;
	int         words_taken = 0;
	int         word_wait = 0;
	int         hold_left = 0;
	bit         calm_take = 1'b0;
	int         quiet = 0;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
		rotr = (x >> s) | (x << (32 - s));
	endfunction

	task automatic restart_hash();
		chain = START_CHAIN;
		fill = 6'd0;
		msg_bits = 64'd0;
	endtask

	// Run the 64 rounds over the full block buffer and fold into the chain.
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		int t;
		for (t = 0; t < 16; t++)
			w[t] = {blk[4 * t], blk[4 * t + 1], blk[4 * t + 2], blk[4 * t + 3]};
		for (t = 16; t < 64; t++) begin
			s0 = rotr(w[t - 15], 7) ^ rotr(w[t - 15], 18) ^ (w[t - 15] >> 3);
			s1 = rotr(w[t - 2], 17) ^ rotr(w[t - 2], 19) ^ (w[t - 2] >> 10);
			w[t] = w[t - 16] + s0 + w[t - 7] + s1;
		end
		v = chain;
		for (t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (t = 0; t < 8; t++)
			chain[t] = chain[t] + v[t];
	endtask

	task automatic take_byte(input logic [7:0] b);
		blk[fill] = b;
		fill = fill + 6'd1;
		if (fill == 6'd0)
			compress_block();
	endtask

	// Absorb one accepted word; on end of message pad, finish and queue the
	// eight digest words, then start over from the initial chain.
	task automatic hash_absorb(input logic [7:0] b, input logic has, input logic eom);
		logic [63:0]  len;
		digest_part_t d;
		int k;
		if (has) begin
			msg_bits = msg_bits + 64'd8;
			take_byte(b);
		end
		if (eom) begin
			len = msg_bits;
			take_byte(PAD_BYTE);
			while (fill != LEN_OFFSET)
				take_byte(8'h00);
			for (k = 0; k < 8; k++)
				take_byte(len[8 * (7 - k) +: 8]);
			for (k = 0; k < 8; k++) begin
				d.word = chain[k];
				d.idx = 3'(k);
				d.last = (k == 7);
				digest_due.push_back(d);
			end
			restart_hash();
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic queue_word(input logic [7:0] data, input logic has, input logic eom);
		feed_item_t it;
		it.data = data;
		it.has = has;
		it.eom = eom;
		it.gap = calm_feed ? 0 : $urandom_range(0, 13);
		it.drain = drain_next;
		drain_next = 1'b0;
		byte_feed.push_back(it);
		if (has || eom)
			feed_count++;
	endtask

	// Queue one message of random content; close it either on its last byte or
	// with an empty final word. Sprinkle idle words in as noise.
	task automatic queue_message(input int len);
		bit eom_on_byte;
		int i;
		eom_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			queue_word(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (i == len - 1));
		end
		if (!eom_on_byte)
			queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	function automatic int boundary_len();
		case ($urandom_range(0, 3))
			0: boundary_len = 55;
			1: boundary_len = 56;
			2: boundary_len = 63;
			default: boundary_len = 64;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Byte-channel driver: hold a word until accepted, then idle for its gap and
	// offer the next one. A word marked drain waits until no digest is due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			feed_idle = 0;
			cur_gap = 0;
			restart_hash();
		end else begin
			feed_offer = byte_valid;
			if (byte_valid && !byte_stall) begin
				hash_absorb(data_byte, has_byte, end_of_message);
				feed_offer = 1'b0;
				feed_idle = cur_gap;
			end
			if (!feed_offer) begin
				if (feed_idle > 0) begin
					feed_idle--;
				end else if (byte_feed.size() > 0
						&& !(byte_feed[0].drain && digest_due.size() > 0)) begin
					feed_now = byte_feed.pop_front();
					data_byte <= feed_now.data;
					has_byte <= feed_now.has;
					end_of_message <= feed_now.eom;
					cur_gap = feed_now.gap;
					feed_offer = 1'b1;
				end
			end
			byte_valid <= feed_offer;
		end
	end

	// Digest monitor: compare each accepted word with the oldest prediction.
	// Stall a random number of valid cycles before each word; once, after the
	// second digest, hold off for a long stretch so the unit backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_stall <= 1'b0;
			word_wait = 0;
			hold_left = 0;
		end else begin
			if (digest_valid && !digest_stall) begin
				if (digest_due.size() == 0) begin
					report_mismatch($sformatf("digest word %08h with no digest due",
						digest_word));
				end else begin
					if (digest_word !== digest_due[0].word)
						report_mismatch($sformatf("digest_word %08h, want %08h",
							digest_word, digest_due[0].word));
					if (word_index !== digest_due[0].idx)
						report_mismatch($sformatf("word_index %0d, want %0d",
							word_index, digest_due[0].idx));
					if (last_word !== digest_due[0].last)
						report_mismatch($sformatf("last_word %0b, want %0b",
							last_word, digest_due[0].last));
					void'(digest_due.pop_front());
				end
				words_taken++;
				if (last_word)
					calm_take = ($urandom_range(0, 3) == 0);
				word_wait = calm_take ? 0 : $urandom_range(0, 13);
				if (words_taken == HOLD_AT_WORD)
					hold_left = HOLD_CYCLES;
			end else if (digest_valid && word_wait > 0) begin
				word_wait--;
			end
			if (hold_left > 0)
				hold_left--;
			digest_stall <= (word_wait > 0) || (hold_left > 0);
		end
	end

	// Watchdog: end the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (digest_valid && !digest_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int start_count;

		// Directed: empty message, idle word, byte closing the message,
		// extreme byte values, empty final word after bytes, bit patterns.
		calm_feed = 1'b1;
		queue_word(8'h00, 1'b0, 1'b1);
		queue_word(8'h5a, 1'b0, 1'b0);
		queue_word(8'h61, 1'b1, 1'b0);
		queue_word(8'h62, 1'b1, 1'b0);
		queue_word(8'h63, 1'b1, 1'b1);
		calm_feed = 1'b0;
		queue_word(8'h00, 1'b1, 1'b1);
		queue_word(8'hff, 1'b1, 1'b0);
		queue_word(8'ha5, 1'b0, 1'b0);
		queue_word(8'hff, 1'b0, 1'b1);
		drain_next = 1'b1;
		queue_word(8'h55, 1'b1, 1'b0);
		queue_word(8'haa, 1'b1, 1'b0);
		queue_word(8'h0f, 1'b1, 1'b0);
		queue_word(8'hf0, 1'b1, 1'b1);

		// Random: mostly short messages, with block-boundary lengths now and
		// then (padding that fits, padding that spills, exactly one block).
		start_count = feed_count;
		drain_next = 1'b1;
		calm_feed = 1'b0;
		queue_message(boundary_len());
		while (feed_count - start_count < RANDOM_ITEMS) begin
			calm_feed = ($urandom_range(0, 3) == 0);
			drain_next = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 5) == 0)
				queue_message(boundary_len());
			else
				queue_message($urandom_range(0, 12));
		end

		while (byte_feed.size() > 0 || byte_valid)
			@(posedge clk);
		while (digest_due.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/core/s256_pkg.sv
rtl/core/s256_ram.sv
rtl/core/sha256_byte_stream_hash_unit.sv
test/sha256_byte_stream_hash_unit_test.sv
